>>> hdl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types, opcodes and constants of the box push-out collision core
// ----------------------------------------------------------------------------
package aabb_pkg;

  // table size, tied to the 9-bit entry index and 10-bit box count
  localparam int MAX_BOXES = 512;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;
  localparam logic [2:0] REG_COUNT = 3'd6;

  // fixed point constants
  localparam logic [16:0] FRAC_ONE        = 17'd65536;
  localparam logic [16:0] DOOR_OPEN_LIMIT = 17'd58983;

  // entry kind bits
  localparam int KIND_SOLID     = 0;
  localparam int KIND_NOCOLLIDE = 1;
  localparam int KIND_DOOR      = 2;

  // entry word: bounds (lo xyz, hi xyz), kind, fraction
  localparam int ENTRY_W = 192 + 3 + 17;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture input item, clear result
    logic mem_rd;      // read entry at walk index
    logic step_query;  // apply read entry to mover
    logic step_tick;   // update door of read entry
    logic clear_res;   // zero mover position (never raised by the controller)
  } aabb_cmd_t;

endpackage

>>> hdl/aabb_pushout_collision_core.sv
// ----------------------------------------------------------------------------
// aabb_pushout_collision_core
// box table with door ticks and minimum-penetration push-out queries
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | opcode, entry_index, coords, flags, amount
//  out     | output    | out_valid/stall  | out_pos_xyz, hit, zero_vel_xyz
//  cfg     | input     | apb psel/penable | mover offsets, box_count
//
// an entry write or no-op goes from the accepting idle state straight to the
// output state; a tick or query walks min(box_count, MAX_BOXES) entries, one
// table read state and one step state per entry through the single read port
// of the table, then a closing read state and the output state
// one item at a time: input is stalled until the result is transferred
// reset clears control, config and flags; position and table start as garbage
module aabb_pushout_collision_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [8:0]         entry_index_i,
  input  logic signed [31:0] coord_a_x_i,
  input  logic signed [31:0] coord_a_y_i,
  input  logic signed [31:0] coord_a_z_i,
  input  logic signed [31:0] coord_b_x_i,
  input  logic signed [31:0] coord_b_y_i,
  input  logic signed [31:0] coord_b_z_i,
  input  logic [2:0]         box_flags_i,
  input  logic [16:0]        amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic               hit_o,
  output logic               zero_vel_x_o,
  output logic               zero_vel_y_o,
  output logic               zero_vel_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IdxW = $clog2(aabb_pkg::MAX_BOXES);

  logic signed [31:0] mov_lo_q [3];
  logic signed [31:0] mov_hi_q [3];
  logic [9:0]         count_q;
  logic               cfg_we;
  logic [2:0]         reg_idx;
  aabb_pkg::aabb_cmd_t cmd;
  logic [IdxW-1:0]    walk_idx;
  logic               walk_tick;
  logic signed [31:0] pos [3];
  logic [2:0]         zv;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        mov_lo_q[a] <= '0;
        mov_hi_q[a] <= '0;
      end
      count_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        aabb_pkg::REG_MIN_X: mov_lo_q[0] <= pwdata;
        aabb_pkg::REG_MIN_Y: mov_lo_q[1] <= pwdata;
        aabb_pkg::REG_MIN_Z: mov_lo_q[2] <= pwdata;
        aabb_pkg::REG_MAX_X: mov_hi_q[0] <= pwdata;
        aabb_pkg::REG_MAX_Y: mov_hi_q[1] <= pwdata;
        aabb_pkg::REG_MAX_Z: mov_hi_q[2] <= pwdata;
        aabb_pkg::REG_COUNT: count_q     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      aabb_pkg::REG_MIN_X: prdata = mov_lo_q[0];
      aabb_pkg::REG_MIN_Y: prdata = mov_lo_q[1];
      aabb_pkg::REG_MIN_Z: prdata = mov_lo_q[2];
      aabb_pkg::REG_MAX_X: prdata = mov_hi_q[0];
      aabb_pkg::REG_MAX_Y: prdata = mov_hi_q[1];
      aabb_pkg::REG_MAX_Z: prdata = mov_hi_q[2];
      aabb_pkg::REG_COUNT: prdata = {22'd0, count_q};
      default:             prdata = '0;
    endcase
  end

  aabb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .box_count_i (count_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .walk_idx_o  (walk_idx),
    .walk_tick_o (walk_tick)
  );

  aabb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .walk_idx_i    (walk_idx),
    .walk_tick_i   (walk_tick),
    .opcode_i      (opcode_i),
    .entry_index_i (entry_index_i),
    .coord_a_x_i   (coord_a_x_i),
    .coord_a_y_i   (coord_a_y_i),
    .coord_a_z_i   (coord_a_z_i),
    .coord_b_x_i   (coord_b_x_i),
    .coord_b_y_i   (coord_b_y_i),
    .coord_b_z_i   (coord_b_z_i),
    .box_flags_i   (box_flags_i),
    .amount_i      (amount_i),
    .mov_lo_i      (mov_lo_q),
    .mov_hi_i      (mov_hi_q),
    .pos_o         (pos),
    .hit_o         (hit_o),
    .zv_o          (zv)
  );

  assign out_pos_x_o  = pos[0];
  assign out_pos_y_o  = pos[1];
  assign out_pos_z_o  = pos[2];
  assign zero_vel_x_o = zv[0];
  assign zero_vel_y_o = zv[1];
  assign zero_vel_z_o = zv[2];

endmodule

>>> hdl/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module aabb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/aabb_ctrl.sv
// ----------------------------------------------------------------------------
// aabb_ctrl
// sequencer: accepts items, walks the table for ticks and queries, hands the result to output
// ----------------------------------------------------------------------------
module aabb_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            opcode_i,
  input  logic [9:0]                            box_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output aabb_pkg::aabb_cmd_t                   cmd_o,
  output logic [$clog2(aabb_pkg::MAX_BOXES)-1:0] walk_idx_o,
  output logic                                  walk_tick_o
);

  localparam int IdxW = $clog2(aabb_pkg::MAX_BOXES);
  localparam int CntW = $clog2(aabb_pkg::MAX_BOXES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_q, n_d;
  logic            tick_q, tick_d;
  logic            accept;
  logic [CntW:0]   cnt_ext;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign walk_idx_o  = idx_q[IdxW-1:0];
  assign walk_tick_o = tick_q;
  assign cnt_ext     = {{(CntW + 1 - 10){1'b0}}, box_count_i};

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    tick_d  = tick_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          idx_d  = '0;
          tick_d = (opcode_i == aabb_pkg::OP_TICK);
          n_d    = (cnt_ext > (CntW + 1)'(aabb_pkg::MAX_BOXES)) ? CntW'(aabb_pkg::MAX_BOXES)
                                                                : cnt_ext[CntW-1:0];
          if ((opcode_i == aabb_pkg::OP_TICK) || (opcode_i == aabb_pkg::OP_QUERY)) begin
            state_d = S_READ;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_READ: begin
        if (idx_q == n_q) begin
          state_d = S_OUT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step_query = !tick_q;
        cmd_o.step_tick  = tick_q;
        idx_d   = idx_q + CntW'(1);
        state_d = S_READ;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      tick_q  <= tick_d;
    end
  end

endmodule

>>> hdl/aabb_dp.sv
// ----------------------------------------------------------------------------
// aabb_dp
// datapath: entry table, mover position, push-out and door update
// ----------------------------------------------------------------------------
module aabb_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  aabb_pkg::aabb_cmd_t                   cmd_i,
  input  logic [$clog2(aabb_pkg::MAX_BOXES)-1:0] walk_idx_i,
  input  logic                                  walk_tick_i,
  input  logic [1:0]                            opcode_i,
  input  logic [8:0]                            entry_index_i,
  input  logic signed [31:0]                    coord_a_x_i,
  input  logic signed [31:0]                    coord_a_y_i,
  input  logic signed [31:0]                    coord_a_z_i,
  input  logic signed [31:0]                    coord_b_x_i,
  input  logic signed [31:0]                    coord_b_y_i,
  input  logic signed [31:0]                    coord_b_z_i,
  input  logic [2:0]                            box_flags_i,
  input  logic [16:0]                           amount_i,
  input  logic signed [31:0]                    mov_lo_i [3],
  input  logic signed [31:0]                    mov_hi_i [3],
  output logic signed [31:0]                    pos_o [3],
  output logic                                  hit_o,
  output logic [2:0]                            zv_o
);

  localparam int IdxW = $clog2(aabb_pkg::MAX_BOXES);
  localparam int EW   = aabb_pkg::ENTRY_W;

  logic signed [31:0] pos_q [3];
  logic               hit_q;
  logic [2:0]         zv_q;
  logic [15:0]        half_q;

  logic               ld_we, we;
  logic [IdxW-1:0]    waddr, raddr;
  logic [EW-1:0]      wdata, rdata, ld_word, tick_word;
  logic               idx_ok;

  logic signed [31:0] b_lo [3];
  logic signed [31:0] b_hi [3];
  logic [2:0]         kind;
  logic [16:0]        frac;
  logic signed [32:0] wlo [3];
  logic signed [32:0] whi [3];
  logic signed [33:0] lo_ov [3];
  logic signed [33:0] hi_ov [3];
  logic signed [33:0] ov [3];
  logic [2:0]         ax_ov;
  logic               eligible, overlap;
  logic [1:0]         ax;
  logic signed [34:0] npos;
  logic signed [31:0] npos_sat;
  logic [17:0]        fsum;
  logic [16:0]        fnew;
  logic               door_move;

  // unpack the entry read back from the table
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      b_lo[a] = rdata[32*a +: 32];
      b_hi[a] = rdata[96 + 32*a +: 32];
    end
    kind = rdata[194:192];
    frac = rdata[211:195];
  end

  // write word for an entry write
  assign ld_word = {amount_i, box_flags_i, coord_b_z_i, coord_b_y_i, coord_b_x_i,
                    coord_a_z_i, coord_a_y_i, coord_a_x_i};
  assign idx_ok  = ({1'b0, entry_index_i} < 10'(aabb_pkg::MAX_BOXES));
  assign ld_we   = cmd_i.load_item && (opcode_i == aabb_pkg::OP_WRITE) && idx_ok;

  // door advance
  assign door_move = kind[aabb_pkg::KIND_DOOR] && (frac != '0)
                     && (frac < aabb_pkg::FRAC_ONE);
  assign fsum      = {1'b0, frac} + {2'b00, half_q};
  assign fnew      = (fsum > {1'b0, aabb_pkg::FRAC_ONE}) ? aabb_pkg::FRAC_ONE
                                                         : fsum[16:0];
  assign tick_word = {fnew, rdata[194:0]};

  // table write mux
  always_comb begin
    we    = ld_we;
    waddr = entry_index_i[IdxW-1:0];
    wdata = ld_word;
    if (cmd_i.step_tick && walk_tick_i && door_move) begin
      we    = 1'b1;
      waddr = walk_idx_i;
      wdata = tick_word;
    end
  end
  assign raddr = walk_idx_i;

  aabb_ram #(.Width(EW), .Depth(aabb_pkg::MAX_BOXES)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // overlap and least-overlap axis
  always_comb begin
    overlap = 1'b1;
    for (int a = 0; a < 3; a++) begin
      wlo[a]   = 33'(pos_q[a]) + 33'(mov_lo_i[a]);
      whi[a]   = 33'(pos_q[a]) + 33'(mov_hi_i[a]);
      if (!((wlo[a] < 33'(b_hi[a])) && (whi[a] > 33'(b_lo[a])))) overlap = 1'b0;
      lo_ov[a] = 34'(whi[a]) - 34'(b_lo[a]);
      hi_ov[a] = 34'(b_hi[a]) - 34'(wlo[a]);
      ax_ov[a] = lo_ov[a] < hi_ov[a];
      ov[a]    = ax_ov[a] ? lo_ov[a] : hi_ov[a];
    end
    eligible = kind[aabb_pkg::KIND_SOLID] && !kind[aabb_pkg::KIND_NOCOLLIDE]
               && !(kind[aabb_pkg::KIND_DOOR] && (frac >= aabb_pkg::DOOR_OPEN_LIMIT));
    if ((ov[0] <= ov[1]) && (ov[0] <= ov[2])) ax = 2'd0;
    else if (ov[1] <= ov[2])                  ax = 2'd1;
    else                                      ax = 2'd2;
    npos = ax_ov[ax] ? (35'(pos_q[ax]) - 35'(ov[ax])) : (35'(pos_q[ax]) + 35'(ov[ax]));
    if (npos > 35'sd2147483647)       npos_sat = 32'sh7fffffff;
    else if (npos < -35'sd2147483648) npos_sat = 32'sh80000000;
    else                              npos_sat = npos[31:0];
  end

  // mover and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      zv_q  <= '0;
    end else if (cmd_i.load_item) begin
      hit_q <= 1'b0;
      zv_q  <= '0;
    end else if (cmd_i.step_query && eligible && overlap) begin
      hit_q    <= 1'b1;
      zv_q[ax] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      half_q <= amount_i[16:1];
      if (opcode_i == aabb_pkg::OP_QUERY) begin
        pos_q[0] <= coord_a_x_i;
        pos_q[1] <= coord_a_y_i;
        pos_q[2] <= coord_a_z_i;
      end else begin
        for (int a = 0; a < 3; a++) pos_q[a] <= '0;
      end
    end else if (cmd_i.clear_res) begin
      for (int a = 0; a < 3; a++) pos_q[a] <= '0;
    end else if (cmd_i.step_query && eligible && overlap) begin
      pos_q[ax] <= npos_sat;
    end
  end

  assign pos_o = pos_q;
  assign hit_o = hit_q;
  assign zv_o  = zv_q;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the box push-out collision core: a queued driver
// offers entry writes, door ticks, queries and no-ops, a predictor mirrors
// the box table and mover registers, and a monitor checks every result
// transfer against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX = aabb_pkg::MAX_BOXES;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [8:0]         idx;
    logic signed [31:0] ca [3];
    logic signed [31:0] cb [3];
    logic [2:0]         flags;
    logic [16:0]        amount;
  } box_item_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic               hit;
    logic               zv [3];
  } push_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = '0;
  logic [8:0]         entry_index_i = '0;
  logic signed [31:0] coord_a_x_i = '0, coord_a_y_i = '0, coord_a_z_i = '0;
  logic signed [31:0] coord_b_x_i = '0, coord_b_y_i = '0, coord_b_z_i = '0;
  logic [2:0]         box_flags_i = '0;
  logic [16:0]        amount_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic               hit_o, zero_vel_x_o, zero_vel_y_o, zero_vel_z_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  aabb_pushout_collision_core uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state: table mirror and mover registers
  longint      tbl_lo [NBOX][3];
  longint      tbl_hi [NBOX][3];
  logic [2:0]  tbl_kind [NBOX];
  logic [16:0] tbl_frac [NBOX];
  longint      mov_lo [3];
  longint      mov_hi [3];
  logic [9:0]  walk_count;

  box_item_t pending_items [$];
  push_res_t expected_pushes [$];
  box_item_t cur_item;
  bit        in_done = 0;
  int        idle_pct = 22;
  int        rx_hold = 0;
  int        errors = 0;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // apply one item to the mirror and work out its result
  function automatic push_res_t resolve_item(box_item_t it);
    push_res_t r;
    longint pos [3], wlo [3], whi [3], lov [3], hov [3], ov [3];
    int n, ax;
    bit olap;
    logic [16:0] half;
    logic [17:0] f;
    n = (walk_count > NBOX) ? NBOX : walk_count;
    for (int a = 0; a < 3; a++) begin
      pos[a] = 0;
      r.zv[a] = 1'b0;
    end
    r.hit = 1'b0;
    case (it.op)
      aabb_pkg::OP_WRITE: begin
        for (int a = 0; a < 3; a++) begin
          tbl_lo[it.idx][a] = it.ca[a];
          tbl_hi[it.idx][a] = it.cb[a];
        end
        tbl_kind[it.idx] = it.flags;
        tbl_frac[it.idx] = it.amount;
      end
      aabb_pkg::OP_TICK: begin
        half = it.amount >> 1;
        for (int i = 0; i < n; i++) begin
          if (tbl_kind[i][aabb_pkg::KIND_DOOR] && tbl_frac[i] > 0
              && tbl_frac[i] < aabb_pkg::FRAC_ONE) begin
            f = tbl_frac[i] + half;
            tbl_frac[i] = (f > aabb_pkg::FRAC_ONE) ? aabb_pkg::FRAC_ONE : f[16:0];
          end
        end
      end
      aabb_pkg::OP_QUERY: begin
        for (int a = 0; a < 3; a++) pos[a] = it.ca[a];
        for (int i = 0; i < n; i++) begin
          if (!tbl_kind[i][aabb_pkg::KIND_SOLID] || tbl_kind[i][aabb_pkg::KIND_NOCOLLIDE])
            continue;
          if (tbl_kind[i][aabb_pkg::KIND_DOOR] && tbl_frac[i] >= aabb_pkg::DOOR_OPEN_LIMIT)
            continue;
          olap = 1;
          for (int a = 0; a < 3; a++) begin
            wlo[a] = pos[a] + mov_lo[a];
            whi[a] = pos[a] + mov_hi[a];
            if (!(wlo[a] < tbl_hi[i][a] && whi[a] > tbl_lo[i][a])) olap = 0;
          end
          if (!olap) continue;
          for (int a = 0; a < 3; a++) begin
            lov[a] = whi[a] - tbl_lo[i][a];
            hov[a] = tbl_hi[i][a] - wlo[a];
            ov[a] = (lov[a] < hov[a]) ? lov[a] : hov[a];
          end
          // least overlap, ties go to x then y
          if (ov[0] <= ov[1] && ov[0] <= ov[2]) ax = 0;
          else if (ov[1] <= ov[2]) ax = 1;
          else ax = 2;
          if (lov[ax] < hov[ax]) pos[ax] = sat32(pos[ax] - ov[ax]);
          else pos[ax] = sat32(pos[ax] + ov[ax]);
          r.zv[ax] = 1'b1;
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    for (int a = 0; a < 3; a++) r.pos[a] = pos[a][31:0];
    return r;
  endfunction

  // input side: one transfer per item from the pending queue
  always @(negedge clk_i) begin
    bit v;
    v = in_valid_i;
    if (in_done) begin
      v = 0;
      in_done = 0;
    end
    if (!v && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
      cur_item = pending_items.pop_front();
      opcode_i <= cur_item.op;
      entry_index_i <= cur_item.idx;
      coord_a_x_i <= cur_item.ca[0];
      coord_a_y_i <= cur_item.ca[1];
      coord_a_z_i <= cur_item.ca[2];
      coord_b_x_i <= cur_item.cb[0];
      coord_b_y_i <= cur_item.cb[1];
      coord_b_z_i <= cur_item.cb[2];
      box_flags_i <= cur_item.flags;
      amount_i <= cur_item.amount;
      v = 1;
    end
    in_valid_i <= v;
  end

  // output side stall, with a long hold-off while rx_hold is set
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    push_res_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_pushes.push_back(resolve_item(cur_item));
      in_done = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pushes.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        e = expected_pushes.pop_front();
        if (out_pos_x_o !== e.pos[0])
          report($sformatf("pos x %h want %h", out_pos_x_o, e.pos[0]));
        if (out_pos_y_o !== e.pos[1])
          report($sformatf("pos y %h want %h", out_pos_y_o, e.pos[1]));
        if (out_pos_z_o !== e.pos[2])
          report($sformatf("pos z %h want %h", out_pos_z_o, e.pos[2]));
        if (hit_o !== e.hit) report($sformatf("hit %b want %b", hit_o, e.hit));
        if (zero_vel_x_o !== e.zv[0]) report("zero_vel x");
        if (zero_vel_y_o !== e.zv[1]) report("zero_vel y");
        if (zero_vel_z_o !== e.zv[2]) report("zero_vel z");
      end
    end
  end

  // register write over the apb port, mirrored into the predictor
  task automatic cfg_write(logic [2:0] ridx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {ridx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (ridx < aabb_pkg::REG_MAX_X) mov_lo[ridx] = signed'(val);
    else if (ridx < aabb_pkg::REG_COUNT) mov_hi[ridx - aabb_pkg::REG_MAX_X] = signed'(val);
    else walk_count = val[9:0];
  endtask

  task automatic cfg_mover(logic [31:0] lx, ly, lz, hx, hy, hz, logic [9:0] cnt);
    cfg_write(aabb_pkg::REG_MIN_X, lx);
    cfg_write(aabb_pkg::REG_MIN_Y, ly);
    cfg_write(aabb_pkg::REG_MIN_Z, lz);
    cfg_write(aabb_pkg::REG_MAX_X, hx);
    cfg_write(aabb_pkg::REG_MAX_Y, hy);
    cfg_write(aabb_pkg::REG_MAX_Z, hz);
    cfg_write(aabb_pkg::REG_COUNT, {22'd0, cnt});
  endtask

  // sender pauses until every result is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_pushes.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(9) < 8) return $urandom_range(0, 6 * 65536) - 3 * 65536;
    return $urandom;
  endfunction

  function automatic logic [16:0] rand_frac();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return aabb_pkg::FRAC_ONE;
      2: return aabb_pkg::DOOR_OPEN_LIMIT - $urandom_range(1);
      3: return $urandom_range(131071);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic box_item_t make_item(logic [1:0] op, logic [8:0] idx);
    box_item_t it;
    it.op = op;
    it.idx = idx;
    for (int a = 0; a < 3; a++) begin
      it.ca[a] = rand_coord();
      // mostly a proper box, now and then inverted or arbitrary
      if ($urandom_range(9) == 0) it.cb[a] = $urandom;
      else it.cb[a] = it.ca[a] + $urandom_range(0, 2 * 65536) - ($urandom_range(9) == 0 ? 65536 : 0);
    end
    it.flags = ($urandom_range(3) == 0) ? $urandom_range(7) : {$urandom_range(1), 1'b0, 1'b1};
    it.amount = (op == aabb_pkg::OP_TICK) ? $urandom_range(131071) : rand_frac();
    return it;
  endfunction

  task automatic add_random(int cnt, int hi_idx);
    box_item_t it;
    int r;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(99);
      if (r < 35) it = make_item(aabb_pkg::OP_WRITE, ($urandom_range(4) == 0) ? $urandom_range(511)
                                                                    : $urandom_range(hi_idx));
      else if (r < 50) it = make_item(aabb_pkg::OP_TICK, $urandom);
      else if (r < 95) it = make_item(aabb_pkg::OP_QUERY, $urandom);
      else it = make_item(OP_NOP, $urandom);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    box_item_t it;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int a = 0; a < 3; a++) begin
      mov_lo[a] = 0;
      mov_hi[a] = 0;
    end
    walk_count = '0;

    // directed: fill entries 0..15 with every kind and door fraction edge
    cfg_mover(-32'sd32768, -32'sd32768, -32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768, 10'd16);
    for (int i = 0; i < 16; i++) begin
      it = make_item(aabb_pkg::OP_WRITE, i);
      it.flags = i[2:0];
      case (i)
        4'd5: it.amount = 17'd0;
        4'd6: it.amount = 17'd1;
        4'd7: it.amount = aabb_pkg::DOOR_OPEN_LIMIT - 1;
        4'd13: it.amount = aabb_pkg::DOOR_OPEN_LIMIT;
        4'd14: it.amount = aabb_pkg::FRAC_ONE - 1;
        4'd15: it.amount = 17'h1ffff;
        default: ;
      endcase
      if (i >= 13) it.flags = 3'b101;
      pending_items.push_back(it);
    end
    it = make_item(aabb_pkg::OP_QUERY, 0);
    it.ca = '{32'sh7fffffff, 32'sh80000000, 32'sd0};
    pending_items.push_back(it);
    it.ca = '{32'sd0, 32'sd0, 32'sd0};
    pending_items.push_back(it);
    foreach (it.ca[a]) it.ca[a] = 32'sh80000000;
    pending_items.push_back(it);
    foreach (it.ca[a]) it.ca[a] = 32'sh7fffffff;
    pending_items.push_back(it);
    it = make_item(aabb_pkg::OP_TICK, 0);
    foreach (pending_items[k]) ;
    it.amount = 17'd0;     pending_items.push_back(it);
    it.amount = 17'd1;     pending_items.push_back(it);
    it.amount = 17'd13107; pending_items.push_back(it);
    it.amount = 17'h1ffff; pending_items.push_back(it);
    pending_items.push_back(make_item(OP_NOP, 9'h1ff));
    pending_items.push_back(make_item(aabb_pkg::OP_QUERY, 0));
    drain();

    // random, small table, with a long receiver hold-off at the start
    rx_hold = 400;
    for (int p = 0; p < 6; p++) begin
      add_random(50, 15);
      drain();
      cfg_write(aabb_pkg::REG_COUNT, $urandom_range(16));
    end

    // extreme offsets, no idling at all
    idle_pct = 0;
    cfg_mover(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 10'd16);
    add_random(150, 15);
    drain();
    idle_pct = 22;

    // random offsets, empty walk
    cfg_mover($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 10'd0);
    add_random(50, 15);
    drain();

    // whole table written, then walks at and beyond its size
    for (int i = 0; i < NBOX; i++) pending_items.push_back(make_item(aabb_pkg::OP_WRITE, i));
    drain();
    cfg_mover(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
              10'd1023);
    add_random(10, 511);
    drain();
    cfg_write(aabb_pkg::REG_COUNT, 32'd512);
    add_random(10, 511);
    drain();

    repeat (20) @(negedge clk_i);
    if (errors == 0 && expected_pushes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/aabb_pkg.sv
hdl/aabb_ram.sv
hdl/aabb_ctrl.sv
hdl/aabb_dp.sv
hdl/aabb_pushout_collision_core.sv
dv/tb_top.sv
